// ===== rtl/dp2d_pkg.sv =====
// shared constants, register codes and pipeline payload types for the disk projection block
package dp2d_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int MAG_W      = DATA_WIDTH;
   localparam int SQ_W       = 2 * DATA_WIDTH;
   localparam int N2_W       = SQ_W + 1;
   localparam int ROOT_W     = DATA_WIDTH + 1;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int NUM_W      = 2 * DATA_WIDTH;
   localparam int QUO_W      = DATA_WIDTH;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DATA_WIDTH-1:0] RADIUS_RESET = DATA_WIDTH'(256);

   typedef enum logic [0:0] {
      REG_RADIUS = 1'b0
   } reg_index_type;

   // per-pixel payload carried alongside the arithmetic
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] vec_first;
      logic signed [DATA_WIDTH-1:0] vec_second;
      logic signed [DATA_WIDTH-1:0] center_first;
      logic signed [DATA_WIDTH-1:0] center_second;
      logic                         neg_first;
      logic                         neg_second;
      logic                         outside;
   } pix_type;

   // payload through the root stages: pixel plus both dividends
   typedef struct packed {
      pix_type          pix;
      logic [NUM_W-1:0] num_first;
      logic [NUM_W-1:0] num_second;
   } sq_side_type;

endpackage

// ===== rtl/disk_projection_2d.sv =====
// top level: per-pixel projection of a 2d vector onto a disk of programmable radius
//
//  channel  | kind           | carries
//  ---------+----------------+-----------------------------------------------------
//  req_*    | stream in      | vec_first, vec_second, center_first, center_second
//  rsp_*    | stream out     | proj_first, proj_second in tdata, was_scaled in tuser
//  csr_*    | apb registers  | radius at byte address 0
//
//  one transaction per cycle sustained while the result stream is not held back
//  stages in order: difference, squares and products, norm sum and compare, 17 root stages
//  (one root bit each), 16 divider stages (one quotient bit each), output register
//  all stages advance together; while the output register holds an untaken result
//  the whole pipeline freezes and req_tready is low, nothing is dropped or repeated
//  synchronous active-high reset clears every valid bit and loads radius 1.0 (256)
module disk_projection_2d (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] vec_first, [31:16] vec_second, [47:32] center_first, [63:48] center_second
   input  logic [4*dp2d_pkg::DATA_WIDTH-1:0] req_tdata,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] proj_first, [31:16] proj_second
   output logic [2*dp2d_pkg::DATA_WIDTH-1:0] rsp_tdata,
   // [0] was_scaled
   output logic                            rsp_tuser,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dp2d_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dp2d_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dp2d_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import dp2d_pkg::*;

   localparam int                        EXT_W   = DATA_WIDTH + 2;
   localparam logic signed [EXT_W-1:0]   SAT_MAX = EXT_W'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [EXT_W-1:0]   SAT_MIN = -SAT_MAX - EXT_W'(1);

   // stage 1: differences split into sign and magnitude
   typedef struct packed {
      pix_type          pix;
      logic [MAG_W-1:0] mag_first;
      logic [MAG_W-1:0] mag_second;
   } s1_type;

   // stage 2: squares and radius-scaled magnitudes
   typedef struct packed {
      pix_type          pix;
      logic [SQ_W-1:0]  sq_first;
      logic [SQ_W-1:0]  sq_second;
      logic [NUM_W-1:0] num_first;
      logic [NUM_W-1:0] num_second;
   } s2_type;

   // stage 3: squared norm plus the outside decision
   typedef struct packed {
      sq_side_type     side;
      logic [N2_W-1:0] n2;
   } s3_type;

   // add or subtract the scaled offset to the centre and clip to the signed range
   function automatic logic [DATA_WIDTH-1:0] shrink_sat(
      input logic signed [DATA_WIDTH-1:0] c,
      input logic [QUO_W-1:0]             q,
      input logic                         neg
   );
      logic signed [EXT_W-1:0] ce;
      logic signed [EXT_W-1:0] qe;
      logic signed [EXT_W-1:0] s;
      begin
         ce = EXT_W'(c);
         qe = $signed({2'b00, q});
         s  = neg ? (ce - qe) : (ce + qe);
         if (s > SAT_MAX) begin
            return SAT_MAX[DATA_WIDTH-1:0];
         end else if (s < SAT_MIN) begin
            return SAT_MIN[DATA_WIDTH-1:0];
         end else begin
            return s[DATA_WIDTH-1:0];
         end
      end
   endfunction

   logic                         en;

   logic [DATA_WIDTH-1:0]        radius_ff;
   logic [SQ_W-1:0]              rsq_ff;
   logic                         csr_write;
   reg_index_type                csr_index;

   logic signed [DATA_WIDTH-1:0] req_vec_first;
   logic signed [DATA_WIDTH-1:0] req_vec_second;
   logic signed [DATA_WIDTH-1:0] req_center_first;
   logic signed [DATA_WIDTH-1:0] req_center_second;
   logic signed [DATA_WIDTH:0]   diff_first;
   logic signed [DATA_WIDTH:0]   diff_second;

   s1_type                       s1_in;
   s1_type                       s1_ff;
   logic                         s1_valid_ff;
   s2_type                       s2_in;
   s2_type                       s2_ff;
   logic                         s2_valid_ff;
   s3_type                       s3_in;
   s3_type                       s3_ff;
   logic                         s3_valid_ff;

   logic                         sq_valid;
   logic [ROOT_W-1:0]            sq_root;
   sq_side_type                  sq_side;

   logic                         dv_valid;
   logic [QUO_W-1:0]             dv_quo_first;
   logic [QUO_W-1:0]             dv_quo_second;
   pix_type                      dv_pix;

   logic [2*DATA_WIDTH-1:0]      rsp_tdata_in;
   logic [2*DATA_WIDTH-1:0]      rsp_tdata_ff;
   logic                         rsp_tuser_ff;
   logic                         rsp_tvalid_ff;

   // pipeline moves whenever the output register is free or being emptied
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // register port, pready tied high so writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write && csr_index == REG_RADIUS) begin
         radius_ff <= csr_pwdata[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_RADIUS) begin
         csr_prdata = CSR_DATA_W'(radius_ff);
      end
   end

   // squared radius follows the register in the next cycle
   always_ff @(posedge clock) begin
      rsq_ff <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
   end

   // request unpacking
   assign req_vec_first     = req_tdata[DATA_WIDTH-1:0];
   assign req_vec_second    = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
   assign req_center_first  = req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
   assign req_center_second = req_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH];

   // stage 1: d = x - c, one extra bit so the difference never wraps
   always_comb begin
      diff_first  = {req_vec_first[DATA_WIDTH-1], req_vec_first}
                  - {req_center_first[DATA_WIDTH-1], req_center_first};
      diff_second = {req_vec_second[DATA_WIDTH-1], req_vec_second}
                  - {req_center_second[DATA_WIDTH-1], req_center_second};
      s1_in.pix.vec_first     = req_vec_first;
      s1_in.pix.vec_second    = req_vec_second;
      s1_in.pix.center_first  = req_center_first;
      s1_in.pix.center_second = req_center_second;
      s1_in.pix.neg_first     = diff_first[DATA_WIDTH];
      s1_in.pix.neg_second    = diff_second[DATA_WIDTH];
      s1_in.pix.outside       = 1'b0;
      s1_in.mag_first  = diff_first[DATA_WIDTH]  ? MAG_W'(-diff_first)  : MAG_W'(diff_first);
      s1_in.mag_second = diff_second[DATA_WIDTH] ? MAG_W'(-diff_second) : MAG_W'(diff_second);
   end

   // stage 2: four independent multipliers
   always_comb begin
      s2_in.pix        = s1_ff.pix;
      s2_in.sq_first   = SQ_W'(s1_ff.mag_first) * SQ_W'(s1_ff.mag_first);
      s2_in.sq_second  = SQ_W'(s1_ff.mag_second) * SQ_W'(s1_ff.mag_second);
      s2_in.num_first  = NUM_W'(s1_ff.mag_first) * NUM_W'(radius_ff);
      s2_in.num_second = NUM_W'(s1_ff.mag_second) * NUM_W'(radius_ff);
   end

   // stage 3: |d|^2 and whether it lies strictly beyond radius^2
   always_comb begin
      s3_in.n2               = N2_W'(s2_ff.sq_first) + N2_W'(s2_ff.sq_second);
      s3_in.side.pix         = s2_ff.pix;
      s3_in.side.pix.outside = (s3_in.n2 > N2_W'(rsq_ff));
      s3_in.side.num_first   = s2_ff.num_first;
      s3_in.side.num_second  = s2_ff.num_second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   // floor(sqrt(|d|^2)), the norm that divides both components
   dp2d_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_ff.n2),
      .in_side   (s3_ff.side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // |d_k| * radius / norm for both components, truncated
   dp2d_div_pipe u_div (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (sq_valid),
      .in_num_first   (sq_side.num_first),
      .in_num_second  (sq_side.num_second),
      .in_den         (sq_root),
      .in_pix         (sq_side.pix),
      .out_valid      (dv_valid),
      .out_quo_first  (dv_quo_first),
      .out_quo_second (dv_quo_second),
      .out_pix        (dv_pix)
   );

   // outside the disk the centre plus the shrunk offset, inside the input unchanged
   always_comb begin
      rsp_tdata_in[DATA_WIDTH-1:0] = dv_pix.outside
         ? shrink_sat(dv_pix.center_first, dv_quo_first, dv_pix.neg_first)
         : dv_pix.vec_first;
      rsp_tdata_in[2*DATA_WIDTH-1:DATA_WIDTH] = dv_pix.outside
         ? shrink_sat(dv_pix.center_second, dv_quo_second, dv_pix.neg_second)
         : dv_pix.vec_second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= dv_pix.outside;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // nothing may come out in the cycle after a reset
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid_ff)
      else $error("result valid straight after reset");

   // an accepted transaction must land in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted transaction missing from first stage");

   // a stalled pipeline keeps its first stage intact
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_valid_ff) && $stable(s1_ff))
      else $error("first stage changed during a stall");

   // the output register only changes content when it was free or taken
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> rsp_tvalid_ff && $stable(rsp_tdata_ff)
      && $stable(rsp_tuser_ff))
      else $error("pending result overwritten");

endmodule

// ===== rtl/dp2d_isqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
module dp2d_isqrt_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [dp2d_pkg::N2_W-1:0]  in_rad,
   input  dp2d_pkg::sq_side_type      in_side,
   output logic                       out_valid,
   output logic [dp2d_pkg::ROOT_W-1:0] out_root,
   output dp2d_pkg::sq_side_type      out_side
);
   import dp2d_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      sq_side_type       side;
   } sq_stage_type;

   sq_stage_type head;
   sq_stage_type src      [ROOT_W];
   sq_stage_type stage_in [ROOT_W];
   sq_stage_type stage_ff [ROOT_W];
   logic         vsrc     [ROOT_W];
   logic         valid_ff [ROOT_W];

   // one restoring step: bring down two radicand bits, try root*4+1
   function automatic sq_stage_type sqrt_step(input sq_stage_type s);
      sq_stage_type     r;
      logic [REM_W-1:0] cand;
      logic [REM_W-1:0] trial;
      begin
         r     = s;
         cand  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
         trial = REM_W'({s.root, 2'b01});
         if (cand >= trial) begin
            r.rem  = cand - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
         end else begin
            r.rem  = cand;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
         end
         r.rad = {s.rad[RAD_W-3:0], 2'b00};
         return r;
      end
   endfunction

   always_comb begin
      head.rad  = RAD_W'(in_rad);
      head.rem  = '0;
      head.root = '0;
      head.side = in_side;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign src[k]  = head;
         assign vsrc[k] = in_valid;
      end else begin : g_link
         assign src[k]  = stage_ff[k-1];
         assign vsrc[k] = valid_ff[k-1];
      end

      assign stage_in[k] = sqrt_step(src[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vsrc[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = stage_ff[ROOT_W-1].root;
   assign out_side  = stage_ff[ROOT_W-1].side;

endmodule

// ===== rtl/dp2d_div_pipe.sv =====
// pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
module dp2d_div_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [dp2d_pkg::NUM_W-1:0]  in_num_first,
   input  logic [dp2d_pkg::NUM_W-1:0]  in_num_second,
   input  logic [dp2d_pkg::ROOT_W-1:0] in_den,
   input  dp2d_pkg::pix_type           in_pix,
   output logic                        out_valid,
   output logic [dp2d_pkg::QUO_W-1:0]  out_quo_first,
   output logic [dp2d_pkg::QUO_W-1:0]  out_quo_second,
   output dp2d_pkg::pix_type           out_pix
);
   import dp2d_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0] prem;
      logic [QUO_W-1:0]  numlo;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   typedef struct packed {
      lane_type [1:0]    lane;
      logic [ROOT_W-1:0] den;
      pix_type           pix;
   } dv_stage_type;

   dv_stage_type head;
   dv_stage_type src      [QUO_W];
   dv_stage_type stage_in [QUO_W];
   dv_stage_type stage_ff [QUO_W];
   logic         vsrc     [QUO_W];
   logic         valid_ff [QUO_W];

   // partial remainder stays below the divisor, so the quotient fits QUO_W bits
   function automatic lane_type div_step(input lane_type l, input logic [ROOT_W-1:0] den);
      lane_type        r;
      logic [ROOT_W:0] t;
      logic            qbit;
      begin
         r    = l;
         t    = {l.prem, l.numlo[QUO_W-1]};
         qbit = (t >= {1'b0, den});
         if (qbit) begin
            r.prem = ROOT_W'(t - {1'b0, den});
         end else begin
            r.prem = ROOT_W'(t);
         end
         r.numlo = {l.numlo[QUO_W-2:0], 1'b0};
         r.quo   = {l.quo[QUO_W-2:0], qbit};
         return r;
      end
   endfunction

   function automatic dv_stage_type div_stage(input dv_stage_type s);
      dv_stage_type r;
      begin
         r         = s;
         r.lane[0] = div_step(s.lane[0], s.den);
         r.lane[1] = div_step(s.lane[1], s.den);
         return r;
      end
   endfunction

   always_comb begin
      head.lane[0].prem  = ROOT_W'(in_num_first[NUM_W-1:QUO_W]);
      head.lane[0].numlo = in_num_first[QUO_W-1:0];
      head.lane[0].quo   = '0;
      head.lane[1].prem  = ROOT_W'(in_num_second[NUM_W-1:QUO_W]);
      head.lane[1].numlo = in_num_second[QUO_W-1:0];
      head.lane[1].quo   = '0;
      head.den           = in_den;
      head.pix           = in_pix;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign src[k]  = head;
         assign vsrc[k] = in_valid;
      end else begin : g_link
         assign src[k]  = stage_ff[k-1];
         assign vsrc[k] = valid_ff[k-1];
      end

      assign stage_in[k] = div_stage(src[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vsrc[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid      = valid_ff[QUO_W-1];
   assign out_quo_first  = stage_ff[QUO_W-1].lane[0].quo;
   assign out_quo_second = stage_ff[QUO_W-1].lane[1].quo;
   assign out_pix        = stage_ff[QUO_W-1].pix;

endmodule

// ===== tb/tb_disk_projection_2d.sv =====
// self-checking testbench for the disk projection block: stream stimulus, apb setup, scoreboard
module tb_disk_projection_2d;
   timeunit 1ns;
   timeprecision 1ps;

   import dp2d_pkg::*;

   // pipeline depth given at the head of the block, plus a little margin
   localparam int SETTLE_CYCLES = 40;
   localparam int RESET_CYCLES  = 9;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 225;
   localparam int LONG_HOLD     = 200;
   localparam int DIR_CASES     = 20;

   // register map: one word per register, anything above is unmapped
   localparam logic [CSR_ADDR_W-1:0] RADIUS_ADDR   = CSR_ADDR_W'(4 * REG_RADIUS);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = CSR_ADDR_W'(4);

   // request word, first field in the lowest bits
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] center_second;
      logic signed [DATA_WIDTH-1:0] center_first;
      logic signed [DATA_WIDTH-1:0] vec_second;
      logic signed [DATA_WIDTH-1:0] vec_first;
   } pix_in_type;

   typedef struct packed {
      logic                         was_scaled;
      logic signed [DATA_WIDTH-1:0] proj_second;
      logic signed [DATA_WIDTH-1:0] proj_first;
   } proj_type;

   // directed row: inputs, then an optional hand-worked expectation
   typedef struct packed {
      logic [DATA_WIDTH-1:0] vf;
      logic [DATA_WIDTH-1:0] vs;
      logic [DATA_WIDTH-1:0] cf;
      logic [DATA_WIDTH-1:0] cs;
      logic                  known;
      logic [DATA_WIDTH-1:0] pf;
      logic [DATA_WIDTH-1:0] ps;
      logic                  sc;
   } dir_case_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [4*DATA_WIDTH-1:0]      req_tdata;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [2*DATA_WIDTH-1:0]      rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [CSR_ADDR_W-1:0]        csr_paddr;
   logic [CSR_DATA_W-1:0]        csr_pwdata;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   // projections still owed by the block, oldest first
   proj_type                     proj_due_q[$];
   // testbench copy of the radius register
   logic [DATA_WIDTH-1:0]        radius_now = RADIUS_RESET;
   int                           mismatch_count = 0;
   // random idling on both sides, switched off for the closing phase
   bit                           idle_on = 1'b1;
   // sender asks the receiver for one long hold-off
   bit                           long_hold_req = 1'b0;

   // hand-worked rows at the reset radius of 1.0; unknown rows go to the predictor
   dir_case_type dir_cases [DIR_CASES] = '{
      // all zero, inside
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0},
      // exactly on the rim, both axes
      '{16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0100, 16'h0000, 1'b0},
      '{16'h0000, 16'hFF00, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'hFF00, 1'b0},
      // twice the radius, pulled back to the rim
      '{16'h0200, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0100, 16'h0000, 1'b1},
      '{16'h0000, 16'hFE00, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'hFF00, 1'b1},
      // widest difference, one radius away from the centre
      '{16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h8100, 16'h0000, 1'b1},
      '{16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 16'h7EFF, 16'h0000, 1'b1},
      '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // vector sits on the centre at the range limits
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF, 1'b0},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h8000, 1'b0},
      // just inside and just outside along the diagonal
      '{16'h00B5, 16'h00B5, 16'h0000, 16'h0000, 1'b1, 16'h00B5, 16'h00B5, 1'b0},
      '{16'h00B6, 16'h00B5, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{16'h0064, 16'hFF38, 16'h0032, 16'h003C, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // one lsb either side of the rim
      '{16'h00FF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h00FF, 16'h0000, 1'b0},
      '{16'h0101, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0100, 16'h0000, 1'b1},
      '{16'h03E8, 16'h03E8, 16'h012C, 16'hFED4, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0},
      // alternating bit patterns
      '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{16'h0180, 16'h0180, 16'h0080, 16'h0080, 1'b0, 16'h0000, 16'h0000, 1'b0}
   };

   disk_projection_2d DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // saturate to the signed word range
   function automatic logic signed [DATA_WIDTH-1:0] clip_word(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return DATA_WIDTH'(hi);
      if (v < lo) return DATA_WIDTH'(lo);
      return DATA_WIDTH'(v);
   endfunction

   // expected projection of one pixel for a given radius
   function automatic proj_type project_onto_disk(input pix_in_type p,
                                                  input logic [DATA_WIDTH-1:0] rad);
      proj_type r;
      longint   d1;
      longint   d2;
      longint   n2;
      longint   r2;
      longint   norm;
      longint   trial;
      longint   rl;
      longint   q;
      int       b;
      d1 = longint'(p.vec_first) - longint'(p.center_first);
      d2 = longint'(p.vec_second) - longint'(p.center_second);
      n2 = d1 * d1 + d2 * d2;
      rl = longint'({1'b0, rad});
      r2 = rl * rl;
      r.proj_first  = p.vec_first;
      r.proj_second = p.vec_second;
      r.was_scaled  = 1'b0;
      if (n2 > r2) begin
         // floor of the square root, one bit at a time
         norm = 0;
         for (b = ROOT_W; b >= 0; b--) begin
            trial = norm | (longint'(1) <<< b);
            if (trial * trial <= n2) norm = trial;
         end
         q = ((d1 < 0 ? -d1 : d1) * rl) / norm;
         r.proj_first = clip_word(d1 < 0 ? longint'(p.center_first) - q
                                         : longint'(p.center_first) + q);
         q = ((d2 < 0 ? -d2 : d2) * rl) / norm;
         r.proj_second = clip_word(d2 < 0 ? longint'(p.center_second) - q
                                          : longint'(p.center_second) + q);
         r.was_scaled = 1'b1;
      end
      return r;
   endfunction

   // random pixel: mostly within twice the current radius of the centre, some on the centre, some anywhere
   function automatic pix_in_type random_pixel(input logic [DATA_WIDTH-1:0] rad);
      pix_in_type p;
      int         mode;
      int         span;
      mode = $urandom_range(0, 9);
      p = pix_in_type'({$urandom, $urandom});
      if (mode == 3) begin
         p.vec_first  = p.center_first;
         p.vec_second = p.center_second;
      end else if (mode > 3) begin
         if (mode == 4) begin
            // no centre
            p.center_first  = '0;
            p.center_second = '0;
         end
         span = (rad == 0) ? 4 : 2 * int'({1'b0, rad});
         p.vec_first  = clip_word(longint'(p.center_first)
                                  + longint'($urandom_range(0, 2 * span)) - span);
         p.vec_second = clip_word(longint'(p.center_second)
                                  + longint'($urandom_range(0, 2 * span)) - span);
      end
      return p;
   endfunction

   // offer one pixel, wait for the handshake, then record what it must produce
   task automatic send_pixel(input pix_in_type p, input proj_type want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      proj_due_q.push_back(want);
   endtask

   // drop the request and let every owed result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (proj_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access until pready, then the bus goes idle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // apb read, compared against the testbench copy
   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("radius: expected %0d, got %0d", want, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one setting of the radius followed by a batch of random pixels
   task automatic run_phase(input logic [DATA_WIDTH-1:0] rad, input int count,
                            input int hold_at, input int pause_at);
      pix_in_type p;
      wait_idle();
      csr_write(RADIUS_ADDR, CSR_DATA_W'(rad));
      radius_now = rad;
      csr_check(RADIUS_ADDR, CSR_DATA_W'(rad));
      for (int n = 0; n < count; n++) begin
         // receiver holds off while requests keep coming, so the pipeline backs up
         if (n == hold_at) long_hold_req = 1'b1;
         // sender stops until the pipeline has drained completely
         if (n == pause_at) wait_idle();
         p = random_pixel(radius_now);
         send_pixel(p, project_onto_disk(p, radius_now));
      end
   endtask

   // receiver: short random stalls plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            // burst of idle cycles, its length drawn at random
            rsp_tready <= 1'b0;
            stall = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // scoreboard: every result transaction against the oldest owed projection
   always @(posedge clock) begin
      proj_type seen;
      proj_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.proj_first  = rsp_tdata[DATA_WIDTH-1:0];
         seen.proj_second = rsp_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
         seen.was_scaled  = rsp_tuser;
         if (proj_due_q.size() == 0) begin
            $error("result transaction with nothing owed: proj_first %0d proj_second %0d",
                   seen.proj_first, seen.proj_second);
            mismatch_count++;
         end else begin
            want = proj_due_q.pop_front();
            if (seen.proj_first !== want.proj_first) begin
               $error("proj_first: expected %0d, got %0d", want.proj_first, seen.proj_first);
               mismatch_count++;
            end
            if (seen.proj_second !== want.proj_second) begin
               $error("proj_second: expected %0d, got %0d", want.proj_second, seen.proj_second);
               mismatch_count++;
            end
            if (seen.was_scaled !== want.was_scaled) begin
               $error("was_scaled: expected %0d, got %0d", want.was_scaled, seen.was_scaled);
               mismatch_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      pix_in_type            p;
      proj_type              want;
      logic [DATA_WIDTH-1:0] phase_radius [PHASES];
      int                    hold_at;
      int                    pause_at;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // smallest, largest, zero, 1.0, then random
      phase_radius[0] = DATA_WIDTH'(1);
      phase_radius[1] = '1;
      phase_radius[2] = '0;
      phase_radius[3] = RADIUS_RESET;
      phase_radius[4] = DATA_WIDTH'($urandom_range(1, 65535));
      phase_radius[5] = DATA_WIDTH'($urandom_range(1, 512));
      phase_radius[6] = DATA_WIDTH'($urandom_range(1, 65535));
      phase_radius[7] = DATA_WIDTH'($urandom_range(1, 4096));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // radius must come up at 1.0
      csr_check(RADIUS_ADDR, CSR_DATA_W'(RADIUS_RESET));

      // directed table at the reset radius
      foreach (dir_cases[i]) begin
         p.vec_first     = dir_cases[i].vf;
         p.vec_second    = dir_cases[i].vs;
         p.center_first  = dir_cases[i].cf;
         p.center_second = dir_cases[i].cs;
         if (dir_cases[i].known) begin
            want.proj_first  = dir_cases[i].pf;
            want.proj_second = dir_cases[i].ps;
            want.was_scaled  = dir_cases[i].sc;
         end else begin
            want = project_onto_disk(p, radius_now);
         end
         send_pixel(p, want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on  = (ph != PHASES - 1);
         hold_at  = (ph == 1) ? 40 : -1;
         pause_at = (ph == 3) ? 100 : -1;
         if (ph == 4) begin
            // a write above the register map must leave the radius alone
            wait_idle();
            csr_write(ADDR_UNMAPPED, CSR_DATA_W'($urandom));
            csr_check(RADIUS_ADDR, CSR_DATA_W'(radius_now));
         end
         run_phase(phase_radius[ph], PHASE_ITEMS, hold_at, pause_at);
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("disk_projection_2d: match");
      end else begin
         $display("disk_projection_2d: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("disk_projection_2d: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dp2d_pkg.sv
rtl/dp2d_isqrt_pipe.sv
rtl/dp2d_div_pipe.sv
rtl/disk_projection_2d.sv
tb/tb_disk_projection_2d.sv
